[rtl/qoid_pkg.sv]
`timescale 1ns / 1ps

package qoid_pkg;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pixel_t;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_RGB,
    PEND_RGBA,
    PEND_LUMA
  } pend_kind_t;

  // outcome of decoding one byte against the current state
  typedef struct packed {
    pixel_t     pixel;
    pend_kind_t kind;
    logic [2:0] left;
    logic [5:0] luma_g;
    logic       done;
    logic       run;
    logic [5:0] run_len;
  } step_t;

  localparam logic [7:0] OP_RGB  = 8'hfe;
  localparam logic [7:0] OP_RGBA = 8'hff;

  localparam logic [1:0] TAG_INDEX = 2'b00;
  localparam logic [1:0] TAG_DIFF  = 2'b01;
  localparam logic [1:0] TAG_LUMA  = 2'b10;
  localparam logic [1:0] TAG_RUN   = 2'b11;

  localparam logic [2:0] RGB_BYTES  = 3'd3;
  localparam logic [2:0] RGBA_BYTES = 3'd4;

  localparam logic [7:0] DIFF_BIAS    = 8'd2;
  localparam logic [7:0] LUMA_G_BIAS  = 8'd32;
  localparam logic [7:0] LUMA_RB_BIAS = 8'd8;

  localparam logic [2:0] CHANNELS_RGBA = 3'd4;

  localparam logic [1:0] REG_PIXEL_TOTAL  = 2'd0;
  localparam logic [1:0] REG_OUT_CHANNELS = 2'd1;

  localparam pixel_t PIXEL_RESET = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};

  function automatic logic [12:0] pixel_hash(pixel_t p);
    return {5'b0, p.r} * 13'd3 + {5'b0, p.g} * 13'd5 +
           {5'b0, p.b} * 13'd7 + {5'b0, p.a} * 13'd11;
  endfunction

endpackage

[rtl/qoid_ram.sv]
`timescale 1ns / 1ps

module qoid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/qoid_index.sv]
`timescale 1ns / 1ps

module qoid_index import qoid_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr,
  input  logic                       wr_en,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr,
  input  pixel_t                     wr_data,
  output pixel_t                     rd_data
);

  localparam int AW = $clog2(ENTRIES);

  logic [ENTRIES-1:0] vld_r;
  logic [AW-1:0]      rd_addr_r;
  logic               fwd_r;
  pixel_t             fwd_data_r;
  logic [31:0]        ram_q;

  qoid_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // entries never written read as zero; a write in the read cycle is forwarded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      fwd_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        fwd_r <= wr_en && (wr_addr == rd_addr);
      end
    end
    if (rd_en) begin
      rd_addr_r  <= rd_addr;
      fwd_data_r <= wr_data;
    end
  end

  always_comb begin
    if (fwd_r) begin
      rd_data = fwd_data_r;
    end else if (vld_r[rd_addr_r]) begin
      rd_data = pixel_t'(ram_q);
    end else begin
      rd_data = '0;
    end
  end

endmodule

[rtl/qoid_step.sv]
`timescale 1ns / 1ps

module qoid_step import qoid_pkg::*; (
  input  logic [7:0] chunk_byte,
  input  pixel_t     cur,
  input  pend_kind_t kind,
  input  logic [2:0] left,
  input  logic [5:0] luma_g,
  input  pixel_t     idx_pixel,
  output step_t      step
);

  logic [7:0] vg;
  logic [2:0] total;
  logic [2:0] pos;
  logic [2:0] left_dec;

  always_comb begin
    vg       = {2'b0, luma_g} - LUMA_G_BIAS;
    total    = (kind == PEND_RGB) ? RGB_BYTES : RGBA_BYTES;
    pos      = total - left;
    left_dec = left - 3'd1;

    step.pixel   = cur;
    step.kind    = kind;
    step.left    = left;
    step.luma_g  = luma_g;
    step.done    = 1'b0;
    step.run     = 1'b0;
    step.run_len = chunk_byte[5:0];

    case (kind)
      PEND_LUMA: begin
        step.pixel.r = cur.r + vg - LUMA_RB_BIAS + {4'b0, chunk_byte[7:4]};
        step.pixel.g = cur.g + vg;
        step.pixel.b = cur.b + vg - LUMA_RB_BIAS + {4'b0, chunk_byte[3:0]};
        step.kind    = PEND_NONE;
        step.left    = 3'd0;
        step.done    = 1'b1;
      end
      PEND_RGB, PEND_RGBA: begin
        case (pos[1:0])
          2'd0:    step.pixel.r = chunk_byte;
          2'd1:    step.pixel.g = chunk_byte;
          2'd2:    step.pixel.b = chunk_byte;
          default: step.pixel.a = chunk_byte;
        endcase
        step.left = left_dec;
        if (left_dec == 3'd0) begin
          step.kind = PEND_NONE;
          step.done = 1'b1;
        end
      end
      default: begin
        if (chunk_byte == OP_RGB) begin
          step.kind = PEND_RGB;
          step.left = RGB_BYTES;
        end else if (chunk_byte == OP_RGBA) begin
          step.kind = PEND_RGBA;
          step.left = RGBA_BYTES;
        end else begin
          case (chunk_byte[7:6])
            TAG_INDEX: begin
              step.pixel = idx_pixel;
              step.done  = 1'b1;
            end
            TAG_DIFF: begin
              step.pixel.r = cur.r + {6'b0, chunk_byte[5:4]} - DIFF_BIAS;
              step.pixel.g = cur.g + {6'b0, chunk_byte[3:2]} - DIFF_BIAS;
              step.pixel.b = cur.b + {6'b0, chunk_byte[1:0]} - DIFF_BIAS;
              step.done    = 1'b1;
            end
            TAG_LUMA: begin
              step.kind   = PEND_LUMA;
              step.left   = 3'd1;
              step.luma_g = chunk_byte[5:0];
            end
            default: begin
              step.done = 1'b1;
              step.run  = 1'b1;
            end
          endcase
        end
      end
    endcase
  end

endmodule

[rtl/qoi_chunk_decoder.sv]
`timescale 1ns / 1ps

// QOI chunk decoder: takes one chunk-stream byte per cycle and gives at most
// one decoded RGBA pixel per cycle when not stalled. A byte is registered on
// entry while the colour index RAM is read at its low six bits; it is then
// decoded against the current pixel and the result registered. Partial RGB,
// RGBA and LUMA bytes give no pixel. A run byte gives its length plus one
// pixels, one a cycle while out_stall is low, and holds the input stalled
// meanwhile; the one result register is the only other limit on rate. The
// index needs no clearing pass after reset: per-entry valid bits make
// unwritten entries read as zero. Once pixel_total pixels are out, further
// bytes are taken and dropped. Configuration is to be written only while the
// block is idle; the block does not enforce this.
module qoi_chunk_decoder import qoid_pkg::*; #(
  parameter int INDEX_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_chunk_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic        out_store_alpha,
  output logic        out_image_last,
  output logic        out_item_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [28:0] cfg_data
);

  localparam int IW = $clog2(INDEX_ENTRIES);

  logic        byte_v_r;
  logic [7:0]  byte_r;
  pixel_t      cur_r;
  pend_kind_t  kind_r;
  logic [2:0]  left_r;
  logic [5:0]  luma_g_r;
  logic [28:0] done_r;
  logic [28:0] total_r;
  logic [2:0]  chans_r;
  logic [5:0]  run_left_r;
  logic [5:0]  run_left_nxt;
  logic        out_valid_r;
  pixel_t      out_pixel_r;
  logic        out_image_last_r;
  logic        out_item_last_r;

  pixel_t      idx_pixel;
  step_t       step;
  logic        in_accept;
  logic        out_free;
  logic        exe_fire;
  logic        complete;
  logic        chunk_emit;
  logic        run_emit;
  logic        emit;
  logic [29:0] done_inc;
  logic        img_last;
  logic        item_last;
  logic [12:0] hash;

  qoid_index #(.ENTRIES(INDEX_ENTRIES)) u_index (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .rd_addr (in_chunk_byte[IW-1:0]),
    .wr_en   (chunk_emit),
    .wr_addr (hash[IW-1:0]),
    .wr_data (step.pixel),
    .rd_data (idx_pixel)
  );

  qoid_step u_step (
    .chunk_byte (byte_r),
    .cur        (cur_r),
    .kind       (kind_r),
    .left       (left_r),
    .luma_g     (luma_g_r),
    .idx_pixel  (idx_pixel),
    .step       (step)
  );

  assign out_free   = !out_valid_r || !out_stall;
  assign exe_fire   = byte_v_r && (run_left_r == 6'd0) && out_free;
  assign in_stall   = byte_v_r && !exe_fire;
  assign in_accept  = in_valid && !in_stall;
  assign complete   = done_r >= total_r;
  assign chunk_emit = exe_fire && !complete && step.done;
  assign run_emit   = (run_left_r != 6'd0) && out_free;
  assign emit       = chunk_emit || run_emit;
  assign done_inc   = {1'b0, done_r} + 30'd1;
  assign img_last   = done_inc == {1'b0, total_r};
  assign hash       = pixel_hash(step.pixel);
  assign cfg_ready  = 1'b1;

  always_comb begin
    run_left_nxt = run_left_r;
    item_last    = img_last;
    if (chunk_emit) begin
      item_last = img_last || !step.run || (step.run_len == 6'd0);
      if (step.run && !img_last) begin
        run_left_nxt = step.run_len;
      end
    end else if (run_emit) begin
      item_last    = img_last || (run_left_r == 6'd1);
      run_left_nxt = img_last ? 6'd0 : run_left_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_v_r    <= 1'b0;
      cur_r       <= PIXEL_RESET;
      kind_r      <= PEND_NONE;
      left_r      <= 3'd0;
      luma_g_r    <= 6'd0;
      done_r      <= '0;
      total_r     <= 29'd1;
      chans_r     <= CHANNELS_RGBA;
      run_left_r  <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      byte_v_r   <= in_accept || (byte_v_r && !exe_fire);
      run_left_r <= run_left_nxt;
      if (exe_fire && !complete) begin
        cur_r    <= step.pixel;
        kind_r   <= step.kind;
        left_r   <= step.left;
        luma_g_r <= step.luma_g;
      end
      if (emit) begin
        done_r <= done_inc[28:0];
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_PIXEL_TOTAL:  total_r <= cfg_data;
          REG_OUT_CHANNELS: chans_r <= cfg_data[2:0];
          default:          ;
        endcase
      end
    end
    if (in_accept) begin
      byte_r <= in_chunk_byte;
    end
    if (emit) begin
      out_pixel_r      <= chunk_emit ? step.pixel : cur_r;
      out_image_last_r <= img_last;
      out_item_last_r  <= item_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red         = out_pixel_r.r;
  assign out_green       = out_pixel_r.g;
  assign out_blue        = out_pixel_r.b;
  assign out_alpha       = out_pixel_r.a;
  assign out_store_alpha = chans_r == CHANNELS_RGBA;
  assign out_image_last  = out_image_last_r;
  assign out_item_last   = out_item_last_r;

endmodule

[rtl/qoid_checker.sv]
`timescale 1ns / 1ps

module qoid_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_chunk_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic [7:0]  out_alpha,
  input logic        out_store_alpha,
  input logic        out_image_last,
  input logic        out_item_last,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [28:0] cfg_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green) &&
      $stable(out_blue) && $stable(out_alpha) && $stable(out_image_last) &&
      $stable(out_item_last))
    else $error("stalled result changed");

  // the final pixel always closes the byte that caused it
  a_last_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_last |-> out_item_last)
    else $error("image_last without item_last");

  // a run keeps going with the same colour straight after each transfer
  a_run_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_item_last |=> out_valid &&
      out_red == $past(out_red) && out_green == $past(out_green) &&
      out_blue == $past(out_blue) && out_alpha == $past(out_alpha))
    else $error("run copy missing or changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind qoi_chunk_decoder qoid_checker u_chk (.*);
